// File: rtl/core/bayer_demosaic_3x3_defines.svh
// Assertion macros shared by the demosaic core modules.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BAYER_DEMOSAIC_3X3_DEFINES_SVH
`define BAYER_DEMOSAIC_3X3_DEFINES_SVH

// The condition must hold at every clock edge out of reset.
`define BD3_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BD3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BD3_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bd3_pkg.sv
// Shared types, constants and helper functions of the Bayer demosaic core.
// Used by the configuration block, controller, datapath and top level.
`timescale 1ns / 1ps

package bd3_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 2048;
    localparam int unsigned MAX_HEIGHT    = 4096;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned WIDTH_W  = 12;
    localparam int unsigned HEIGHT_W = 13;
    localparam int unsigned DIM_W    = 14;
    localparam int unsigned ROW_W    = 13;
    localparam int unsigned OROW_W   = 12;
    localparam int unsigned SUM_W    = 10;
    localparam int unsigned ACC_W    = 11;
    localparam int unsigned CNT_W    = 3;

    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [DIM_W-1:0]    MIN_DIM    = 14'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SUM,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic sum;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_full;
        logic primed;
        logic out_free;
    } t_sts;

    // Truncating mean of a colour sum over one to four samples.
    function automatic logic [PIX_W-1:0] f_mean(input logic [SUM_W-1:0] sum,
                                               input logic [CNT_W-1:0] cnt);
        logic [19:0]      prod;
        logic [PIX_W-1:0] res;
        prod = 20'(sum) * 20'd683;
        case (cnt)
            3'd1:    res = sum[7:0];
            3'd2:    res = sum[8:1];
            3'd3:    res = prod[18:11];
            3'd4:    res = sum[9:2];
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/core/bayer_demosaic_3x3.sv
// Top level of the 3x3 bilinear Bayer demosaic core.
// Instantiates bd3_cfg, bd3_ctrl and bd3_dpath; depends on bd3_pkg.
//
// Raw samples enter on the s_axis channel (tdata = sample, tuser = 1 for a flush item)
// and RGB pixels leave on the m_axis channel with tlast on the last pixel of the frame.
// Pixels trail the input by image_width+1 samples, so after the last sample of a frame
// the source sends image_width+1 flush items to release the remaining pixels.
// Samples past the end of the frame and flush items sent too early give no pixel.
// An item that makes a pixel passes through load with a line memory read, window
// shift with the line memory write, colour sums, then the mean into the output
// register, where the pixel is then valid. An item that makes no pixel passes
// through load and shift only, and an ignored one is only accepted. The line memory
// port and the shared window path set these steps.
// The output register holds a finished pixel while the sink stalls; the next item is
// accepted meanwhile and waits in its emit step until the register is free.
// Reset clears the control state and sets the frame to 640 by 480; no memory clearing
// pass is needed. Any register write restarts the frame.
`timescale 1ns / 1ps

module bayer_demosaic_3x3 #(
    parameter int unsigned MAX_WIDTH = bd3_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] raw_sample
    input  logic                        i_s_axis_tuser,   // [0] operation
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [23:0]                 o_m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic                        o_m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bd3_pkg::APB_AW-1:0]  paddr,
    input  logic [bd3_pkg::APB_DW-1:0]  pwdata,
    output logic [bd3_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bd3_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [DIM_W-1:0] w_eff_w;
    logic [DIM_W-1:0] w_eff_h;
    logic             w_restart;
    logic [PIX_W-1:0] w_red;
    logic [PIX_W-1:0] w_green;
    logic [PIX_W-1:0] w_blue;

    bd3_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_w   (w_eff_w),
        .o_eff_h   (w_eff_h),
        .o_restart (w_restart)
    );

    bd3_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_op    (i_s_axis_tuser),
        .o_ready (o_s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    bd3_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_op      (i_s_axis_tuser),
        .i_sample  (i_s_axis_tdata),
        .i_eff_w   (w_eff_w),
        .i_eff_h   (w_eff_h),
        .i_restart (w_restart),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_red     (w_red),
        .o_green   (w_green),
        .o_blue    (w_blue),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_blue, w_green, w_red};

endmodule

// File: rtl/core/bd3_cfg.sv
// Configuration registers with the APB-style access port and range clamping.
// Depends on bd3_pkg.
`timescale 1ns / 1ps

module bd3_cfg #(
    parameter int unsigned MAX_WIDTH = bd3_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bd3_pkg::APB_AW-1:0]  paddr,
    input  logic [bd3_pkg::APB_DW-1:0]  pwdata,
    output logic [bd3_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [bd3_pkg::DIM_W-1:0]   o_eff_w,
    output logic [bd3_pkg::DIM_W-1:0]   o_eff_h,
    output logic                        o_restart
);
    import bd3_pkg::*;

    localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic                w_wr;
    logic [DIM_W-1:0]    w_w_ext;
    logic [DIM_W-1:0]    w_h_ext;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    assign o_restart = w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_HEIGHT) begin
                r_height <= pwdata[HEIGHT_W-1:0];
            end else begin
                r_width <= pwdata[WIDTH_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_WIDTH) begin
            prdata = APB_DW'(r_width);
        end else begin
            prdata = APB_DW'(r_height);
        end
    end

    always_comb begin
        w_w_ext = DIM_W'(r_width);
        w_h_ext = DIM_W'(r_height);
        if (w_w_ext < MIN_DIM) begin
            o_eff_w = MIN_DIM;
        end else if (w_w_ext > MAX_W) begin
            o_eff_w = MAX_W;
        end else begin
            o_eff_w = w_w_ext;
        end
        if (w_h_ext < MIN_DIM) begin
            o_eff_h = MIN_DIM;
        end else if (w_h_ext > MAX_H) begin
            o_eff_h = MAX_H;
        end else begin
            o_eff_h = w_h_ext;
        end
    end

endmodule

// File: rtl/core/bd3_ctrl.sv
// Controller state machine that sequences load, shift, sum and emit steps.
// Depends on bd3_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bayer_demosaic_3x3_defines.svh"

module bd3_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_op,
    output logic          o_ready,
    input  bd3_pkg::t_sts i_sts,
    output bd3_pkg::t_cmd o_cmd
);
    import bd3_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_emit;
    logic   n_emit;
    logic   w_act;

    assign w_act = (i_op == OP_SAMPLE) ? !i_sts.in_full : i_sts.in_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && w_act) begin
                    o_cmd.load = 1'b1;
                    n_emit     = (i_op == OP_FLUSH) || i_sts.primed;
                    n_state    = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = r_emit ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `BD3_ASSERT_NXT(a_shift_to_sum, i_clk, i_rst_n, r_state == S_SHIFT && r_emit, r_state == S_SUM, "Shift with a pending pixel did not go on to the sum step.")
    `BD3_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free, "Pixel emitted while the output register was still occupied.")
    `BD3_ASSERT_NXT(a_load_shift, i_clk, i_rst_n, o_cmd.load, r_state == S_SHIFT, "Loaded item was not followed by a shift step.")

endmodule

// File: rtl/core/bd3_dpath.sv
// Datapath: line memory, 3x3 window, position counters, colour sums and output register.
// Depends on bd3_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bayer_demosaic_3x3_defines.svh"

module bd3_dpath #(
    parameter int unsigned MAX_WIDTH = bd3_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bd3_pkg::t_cmd              i_cmd,
    output bd3_pkg::t_sts              o_sts,
    input  logic                       i_op,
    input  logic [bd3_pkg::PIX_W-1:0]  i_sample,
    input  logic [bd3_pkg::DIM_W-1:0]  i_eff_w,
    input  logic [bd3_pkg::DIM_W-1:0]  i_eff_h,
    input  logic                       i_restart,
    output logic                       o_m_valid,
    input  logic                       i_m_ready,
    output logic [bd3_pkg::PIX_W-1:0]  o_red,
    output logic [bd3_pkg::PIX_W-1:0]  o_green,
    output logic [bd3_pkg::PIX_W-1:0]  o_blue,
    output logic                       o_last
);
    import bd3_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    logic [2*PIX_W-1:0] r_line [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic [PIX_W-1:0]   r_sample;
    logic               r_op;
    logic [PIX_W-1:0]   r_win [3][3];

    logic [COL_W-1:0]   r_in_col;
    logic [ROW_W-1:0]   r_in_row;
    logic [COL_W-1:0]   r_out_col;
    logic [OROW_W-1:0]  r_out_row;

    logic [SUM_W-1:0]   r_sum_r;
    logic [SUM_W-1:0]   r_sum_g;
    logic [SUM_W-1:0]   r_sum_b;
    logic [CNT_W-1:0]   r_cnt_r;
    logic [CNT_W-1:0]   r_cnt_g;
    logic [CNT_W-1:0]   r_cnt_b;
    logic               r_last;

    logic               r_m_valid;
    logic [PIX_W-1:0]   r_red;
    logic [PIX_W-1:0]   r_green;
    logic [PIX_W-1:0]   r_blue;
    logic               r_tlast;

    logic [DIM_W-1:0]   w_in_col_x;
    logic [DIM_W-1:0]   w_out_col_x;
    logic [DIM_W-1:0]   w_w_m1;
    logic [DIM_W-1:0]   w_h_m1;
    logic               w_top;
    logic               w_bot;
    logic               w_lft;
    logic               w_rgt;
    logic [ACC_W-1:0]   w_acc_r;
    logic [ACC_W-1:0]   w_acc_g;
    logic [ACC_W-1:0]   w_acc_b;
    logic [CNT_W-1:0]   w_cnt_r;
    logic [CNT_W-1:0]   w_cnt_g;
    logic [CNT_W-1:0]   w_cnt_b;

    assign w_in_col_x  = DIM_W'(r_in_col);
    assign w_out_col_x = DIM_W'(r_out_col);
    assign w_w_m1      = i_eff_w - DIM_W'(1);
    assign w_h_m1      = i_eff_h - DIM_W'(1);

    assign o_sts.in_full  = DIM_W'(r_in_row) >= i_eff_h;
    assign o_sts.primed   = (r_in_row >= ROW_W'(2)) ||
                            (r_in_row == ROW_W'(1) && r_in_col != '0);
    assign o_sts.out_free = !r_m_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_line[r_in_col] <= {r_rd[PIX_W-1:0], r_sample};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd     <= r_line[r_in_col];
            r_sample <= i_sample;
            r_op     <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= r_rd[2*PIX_W-1:PIX_W];
            r_win[2][1] <= r_rd[PIX_W-1:0];
            r_win[2][2] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (i_cmd.shift) begin
                if (w_in_col_x == w_w_m1) begin
                    r_in_col <= '0;
                    if (r_op == OP_SAMPLE) begin
                        r_in_row <= r_in_row + ROW_W'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (i_cmd.emit) begin
                if (r_last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (w_out_col_x == w_w_m1) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + OROW_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end

    assign w_top = (r_out_row == '0);
    assign w_bot = (DIM_W'(r_out_row) == w_h_m1);
    assign w_lft = (r_out_col == '0);
    assign w_rgt = (w_out_col_x == w_w_m1);

    always_comb begin
        logic in_img;
        logic pr;
        logic pc;
        w_acc_r = '0;
        w_acc_g = '0;
        w_acc_b = '0;
        w_cnt_r = '0;
        w_cnt_g = '0;
        w_cnt_b = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                in_img = !((i == 0 && w_top) || (i == 2 && w_bot) ||
                           (j == 0 && w_lft) || (j == 2 && w_rgt));
                pr = r_out_row[0] ^ (i != 1);
                pc = r_out_col[0] ^ (j != 1);
                if (in_img) begin
                    if (pr == pc) begin
                        w_acc_g = w_acc_g + ACC_W'(r_win[j][i]);
                        w_cnt_g = w_cnt_g + CNT_W'(1);
                    end else if (pr) begin
                        w_acc_r = w_acc_r + ACC_W'(r_win[j][i]);
                        w_cnt_r = w_cnt_r + CNT_W'(1);
                    end else begin
                        w_acc_b = w_acc_b + ACC_W'(r_win[j][i]);
                        w_cnt_b = w_cnt_b + CNT_W'(1);
                    end
                end
            end
        end
        if (r_out_row[0] == r_out_col[0]) begin
            w_acc_g = ACC_W'(r_win[1][1]);
            w_cnt_g = CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum_r <= w_acc_r[SUM_W-1:0];
            r_sum_g <= w_acc_g[SUM_W-1:0];
            r_sum_b <= w_acc_b[SUM_W-1:0];
            r_cnt_r <= w_cnt_r;
            r_cnt_g <= w_cnt_g;
            r_cnt_b <= w_cnt_b;
            r_last  <= w_bot && w_rgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_red   <= f_mean(r_sum_r, r_cnt_r);
            r_green <= f_mean(r_sum_g, r_cnt_g);
            r_blue  <= f_mean(r_sum_b, r_cnt_b);
            r_tlast <= r_last;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_last    = r_tlast;

    `BD3_ASSERT_ALWAYS(a_in_col_range, i_clk, i_rst_n, w_in_col_x < i_eff_w, "Input column counter left the row.")
    `BD3_ASSERT_ALWAYS(a_out_col_range, i_clk, i_rst_n, w_out_col_x < i_eff_w, "Output column counter left the row.")
    `BD3_ASSERT_NXT(a_last_restart, i_clk, i_rst_n, i_cmd.emit && r_last, r_in_row == '0 && r_out_row == '0 && r_in_col == '0, "Frame end did not restart the positions.")

endmodule

// File: sim/bayer_demosaic_3x3_tb.sv
// Self-checking testbench for the bayer_demosaic_3x3 streaming core.
// Drives raw Bayer frames and APB register writes and checks each RGB item against a built-in
// bilinear 3x3 predictor or a directed-table pixel. Depends on bd3_pkg and the RTL only.
`timescale 1ns / 1ps

module bayer_demosaic_3x3_tb;
    import bd3_pkg::*;

    localparam int unsigned RING_DEPTH    = 8192;
    localparam int unsigned IDLE_LIMIT    = 1000;
    localparam int unsigned RANDOM_ITEMS  = 1000;
    localparam int unsigned CALM_ITEMS    = 800;
    localparam int unsigned SQUEEZE_AFTER = 300;
    localparam int unsigned HOLD_CYCLES   = 100;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 20;

    typedef enum int {CLR_RED, CLR_GREEN, CLR_BLUE} clr_e;
    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_PIX} chk_e;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pix_t;

    typedef struct packed {
        logic       op;
        logic [7:0] smp;
        chk_e       chk;
        pix_t       px;
    } dir_row_t;

    localparam pix_t PX_NONE      = '0;
    localparam pix_t PX_WHITE     = {8'hFF, 8'hFF, 8'hFF, 1'b0};
    localparam pix_t PX_WHITE_END = {8'hFF, 8'hFF, 8'hFF, 1'b1};
    localparam pix_t PX_BLACK     = {8'h00, 8'h00, 8'h00, 1'b0};
    localparam pix_t PX_BLACK_END = {8'h00, 8'h00, 8'h00, 1'b1};

    // Runs on a 2x2 frame: a flat white frame framed by an early flush and a surplus
    // sample, a flat black frame, then a mixed frame left to the predictor.
    localparam dir_row_t DIR_TAB [0:22] = '{
        '{OP_FLUSH,  8'hFF, CHK_NONE, PX_NONE},
        '{OP_SAMPLE, 8'hFF, CHK_NONE, PX_NONE},
        '{OP_SAMPLE, 8'hFF, CHK_NONE, PX_NONE},
        '{OP_SAMPLE, 8'hFF, CHK_NONE, PX_NONE},
        '{OP_SAMPLE, 8'hFF, CHK_PIX,  PX_WHITE},
        '{OP_SAMPLE, 8'h00, CHK_NONE, PX_NONE},
        '{OP_FLUSH,  8'h00, CHK_PIX,  PX_WHITE},
        '{OP_FLUSH,  8'hFF, CHK_PIX,  PX_WHITE},
        '{OP_FLUSH,  8'h00, CHK_PIX,  PX_WHITE_END},
        '{OP_SAMPLE, 8'h00, CHK_NONE, PX_NONE},
        '{OP_SAMPLE, 8'h00, CHK_NONE, PX_NONE},
        '{OP_SAMPLE, 8'h00, CHK_NONE, PX_NONE},
        '{OP_SAMPLE, 8'h00, CHK_PIX,  PX_BLACK},
        '{OP_FLUSH,  8'hAA, CHK_PIX,  PX_BLACK},
        '{OP_FLUSH,  8'h55, CHK_PIX,  PX_BLACK},
        '{OP_FLUSH,  8'hFF, CHK_PIX,  PX_BLACK_END},
        '{OP_SAMPLE, 8'h01, CHK_PRED, PX_NONE},
        '{OP_SAMPLE, 8'h80, CHK_PRED, PX_NONE},
        '{OP_SAMPLE, 8'hAA, CHK_PRED, PX_NONE},
        '{OP_SAMPLE, 8'h55, CHK_PRED, PX_NONE},
        '{OP_FLUSH,  8'h00, CHK_PRED, PX_NONE},
        '{OP_FLUSH,  8'h00, CHK_PRED, PX_NONE},
        '{OP_FLUSH,  8'h00, CHK_PRED, PX_NONE}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata;
    logic               i_s_axis_tuser;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [23:0]        o_m_axis_tdata;
    logic               o_m_axis_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [7:0]          frame_px [0:RING_DEPTH-1];
    int unsigned         in_row, in_col, out_row, out_col, last_idx;

    pix_t        exp_pix_q [$];
    int unsigned err_cnt;
    int unsigned fed;
    bit          idle_on;
    bit          squeeze;

    bayer_demosaic_3x3 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    function automatic int unsigned frame_width();
        if (width_reg < 2) return 2;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return width_reg;
    endfunction

    function automatic int unsigned frame_height();
        if (height_reg < 2) return 2;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic void restart_frame();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic clr_e site_clr(int r, int c);
        if (((r + c) & 1) == 0) return CLR_GREEN;
        if ((r & 1) != 0) return CLR_RED;
        return CLR_BLUE;
    endfunction

    function automatic pix_t next_pixel(int unsigned w, int unsigned h);
        int unsigned sum [3];
        int unsigned cnt [3];
        logic [7:0]  mean [3];
        int          r, c, di, dj, k;
        clr_e        clr;
        pix_t        px;
        for (k = 0; k < 3; k++) begin
            sum[k] = 0;
            cnt[k] = 0;
        end
        for (di = -1; di <= 1; di++) begin
            for (dj = -1; dj <= 1; dj++) begin
                r = int'(out_row) + di;
                c = int'(out_col) + dj;
                if (r >= 0 && c >= 0 && r < int'(h) && c < int'(w)) begin
                    clr = site_clr(r, c);
                    sum[clr] += frame_px[(r * w + c) % RING_DEPTH];
                    cnt[clr]++;
                end
            end
        end
        if (site_clr(out_row, out_col) == CLR_GREEN) begin
            sum[CLR_GREEN] = frame_px[(out_row * w + out_col) % RING_DEPTH];
            cnt[CLR_GREEN] = 1;
        end
        for (k = 0; k < 3; k++) begin
            mean[k] = (cnt[k] != 0) ? 8'(sum[k] / cnt[k]) : 8'd0;
        end
        px.red   = mean[CLR_RED];
        px.green = mean[CLR_GREEN];
        px.blue  = mean[CLR_BLUE];
        px.last  = (out_row == h - 1 && out_col == w - 1);
        if (px.last) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return px;
    endfunction

    function automatic bit demosaic_step(logic op, logic [7:0] smp, output pix_t px);
        int unsigned w, h;
        w  = frame_width();
        h  = frame_height();
        px = '0;
        if (op == OP_SAMPLE) begin
            if (in_row >= h) return 1'b0;
            last_idx = in_row * w + in_col;
            frame_px[last_idx % RING_DEPTH] = smp;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (last_idx < w + 1) return 1'b0;
        end else if (in_row < h) begin
            return 1'b0;
        end
        px = next_pixel(w, h);
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_item(input logic op, input logic [7:0] smp, input chk_e chk,
                             input pix_t typed);
        pix_t px;
        bit   made;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= smp;
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        made = demosaic_step(op, smp, px);
        if (chk == CHK_PIX) begin
            exp_pix_q.push_back(typed);
        end else if (chk == CHK_PRED && made) begin
            exp_pix_q.push_back(px);
        end
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int unsigned n_smp, input bit noisy);
        int unsigned w, h, k;
        w = frame_width();
        h = frame_height();
        for (k = 0; k < n_smp && k < w * h; k++) begin
            if (noisy && $urandom_range(0, 39) == 0) begin
                push_item(OP_FLUSH, rand_sample(), CHK_PRED, PX_NONE);
            end
            push_item(OP_SAMPLE, rand_sample(), CHK_PRED, PX_NONE);
            fed++;
        end
        if (n_smp >= w * h) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) push_item(OP_SAMPLE, rand_sample(), CHK_PRED,
                                                        PX_NONE);
            end
            repeat (w + 1) begin
                push_item(OP_FLUSH, rand_sample(), CHK_PRED, PX_NONE);
                fed++;
            end
        end
    endtask

    // Stops the source, waits for every pending pixel, then waits out the extra cycles asked for.
    task automatic settle(input int unsigned extra);
        i_s_axis_tvalid <= 1'b0;
        while (exp_pix_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic idx, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== want) begin
            $display("%0t: register %0d read %0d, expected %0d", $time, idx, rd, want);
            err_cnt++;
        end
    endtask

    task automatic set_reg(input logic idx, input int unsigned val);
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b1, idx, APB_DW'(val), rd);
        if (idx == REG_WIDTH) begin
            width_reg = WIDTH_W'(val);
        end else begin
            height_reg = HEIGHT_W'(val);
        end
        restart_frame();
        check_reg(idx, (idx == REG_WIDTH) ? APB_DW'(width_reg) : APB_DW'(height_reg));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (squeeze) begin
                squeeze = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : pixel_check
        pix_t got;
        pix_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[7:0], o_m_axis_tdata[15:8], o_m_axis_tdata[23:16],
                   o_m_axis_tlast};
            if (exp_pix_q.size() == 0) begin
                $display("%0t: unexpected pixel r=%0d g=%0d b=%0d last=%0d", $time,
                         got.red, got.green, got.blue, got.last);
                err_cnt++;
            end else begin
                want = exp_pix_q.pop_front();
                if (got !== want) begin
                    $display("%0t: pixel expected r=%0d g=%0d b=%0d last=%0d", $time,
                             want.red, want.green, want.blue, want.last);
                    $display("%0t:       got      r=%0d g=%0d b=%0d last=%0d", $time,
                             got.red, got.green, got.blue, got.last);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned still;
        still = 0;
        while (still < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready) || (psel && penable)) begin
                still = 0;
            end else begin
                still++;
            end
        end
        $display("%0t: nothing moved for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int unsigned rnd_start, wv, hv, nfr, f, total, n_smp;
        bit          squeezed, tight;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_SAMPLE;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        err_cnt         = 0;
        fed             = 0;
        idle_on         = 1'b1;
        squeeze         = 1'b0;
        squeezed        = 1'b0;
        width_reg       = 12'd640;
        height_reg      = 13'd480;
        last_idx        = 0;
        restart_frame();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_reg(REG_WIDTH, 640);
        check_reg(REG_HEIGHT, 480);
        send_frame(660, 1'b1);
        settle(SETTLE_CYCLES);

        set_reg(REG_WIDTH, 2);
        set_reg(REG_HEIGHT, 2);
        foreach (DIR_TAB[k]) begin
            push_item(DIR_TAB[k].op, DIR_TAB[k].smp, DIR_TAB[k].chk, DIR_TAB[k].px);
        end
        settle(SETTLE_CYCLES);

        // Out-of-range sizes: widest line cut short, tallest frame cut short, smallest frame.
        set_reg(REG_WIDTH, 4095);
        set_reg(REG_HEIGHT, 2);
        send_frame(60, 1'b1);
        settle(SETTLE_CYCLES);
        set_reg(REG_WIDTH, 1);
        set_reg(REG_HEIGHT, 8191);
        send_frame(64, 1'b0);
        settle(SETTLE_CYCLES);
        set_reg(REG_WIDTH, 0);
        set_reg(REG_HEIGHT, 0);
        send_frame(4, 1'b1);
        send_frame(4, 1'b1);
        settle(SETTLE_CYCLES);

        rnd_start = fed;
        while (fed - rnd_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    wv = $urandom_range(0, 1);
                    hv = $urandom_range(0, 3);
                end
                1, 2: begin
                    wv = $urandom_range(11, 24);
                    hv = $urandom_range(2, 4);
                end
                default: begin
                    wv = $urandom_range(2, 8);
                    hv = $urandom_range(2, 6);
                end
            endcase
            tight = !squeezed && (fed - rnd_start > SQUEEZE_AFTER);
            if (tight) begin
                wv = 16;
                hv = 8;
            end
            set_reg(REG_WIDTH, wv);
            set_reg(REG_HEIGHT, hv);
            idle_on = (fed - rnd_start < CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            if (tight) begin
                squeezed = 1'b1;
                squeeze  = 1'b1;
            end
            nfr = $urandom_range(1, 3);
            for (f = 0; f < nfr; f++) begin
                total = frame_width() * frame_height();
                n_smp = total;
                if (!tight && f == nfr - 1 && $urandom_range(0, 4) == 0) begin
                    n_smp = $urandom_range(1, total - 1);
                end
                send_frame(n_smp, 1'b1);
                if (f < nfr - 1 && $urandom_range(0, 5) == 0) settle(0);
            end
            settle(SETTLE_CYCLES);
        end

        settle(0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
